### rtl/core/sprite_oam_pkg.sv
// Package for the sprite attribute table: request and result types,
// mode and status codes, table sizes. No dependencies.
`timescale 1ns / 1ps

package sprite_oam_pkg;

  localparam int POOL_SLOTS  = 64;
  localparam int OAM_ENTRIES = 64;
  localparam int SLOT_W      = 6;

  localparam logic [3:0] MODE_CREATE   = 4'd0;
  localparam logic [3:0] MODE_DESTROY  = 4'd1;
  localparam logic [3:0] MODE_POSITION = 4'd2;
  localparam logic [3:0] MODE_TILE     = 4'd3;
  localparam logic [3:0] MODE_VISIBLE  = 4'd4;
  localparam logic [3:0] MODE_PRIORITY = 4'd5;
  localparam logic [3:0] MODE_DEPTH    = 4'd6;
  localparam logic [3:0] MODE_RENDER   = 4'd7;
  localparam logic [3:0] MODE_HIDE_ALL = 4'd8;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NO_FREE = 2'd1;
  localparam logic [1:0] ST_BAD     = 2'd2;

  localparam logic [15:0] HIDDEN_WORD = 16'h8000;
  localparam logic [15:0] Y_RESET     = 16'hFFC0;

  typedef struct packed {
    logic [3:0]         mode;
    logic [6:0]         slot;
    logic signed [15:0] x_pos;
    logic signed [15:0] y_pos;
    logic [7:0]         tile;
    logic [1:0]         shape;
    logic [1:0]         size_code;
    logic [3:0]         palette;
    logic [1:0]         priority_req;
    logic               show;
    logic [15:0]        depth;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [5:0]  slot_id;
    logic [5:0]  oam_index;
    logic [15:0] attr_zero;
    logic [15:0] attr_one;
    logic [15:0] attr_two;
    logic        last;
  } res_t;

endpackage

### rtl/core/sprite_table_depth_sorted_oam_top.sv
// Sprite attribute table with depth-sorted render.
// Slot updates read-modify-write the addressed slot; create scans the pool for a free slot.
// Render: one full pool scan through the single slot memory read port per emitted
// sprite; trailing hidden entries are emitted without a scan.
// Reset clears control registers and flags only; row valid bits stand in for the table reset values.
// Results are one-cycle strobes; the receiver cannot stall. Depends on sprite_oam_pkg.
`timescale 1ns / 1ps

module sprite_table_depth_sorted_oam_top (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  sprite_oam_pkg::req_t req_i,
  output logic                 busy_o,
  output logic                 res_valid_o,
  output sprite_oam_pkg::res_t res_o
);

  localparam int P = sprite_oam_pkg::POOL_SLOTS;
  localparam int N = sprite_oam_pkg::OAM_ENTRIES;
  localparam int W = sprite_oam_pkg::SLOT_W;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_UPD   = 3'd1;
  localparam logic [2:0] S_CRE   = 3'd2;
  localparam logic [2:0] S_SCAN  = 3'd3;
  localparam logic [2:0] S_FETCH = 3'd4;
  localparam logic [2:0] S_EMIT  = 3'd5;

  typedef struct packed {
    logic [15:0] y;
    logic [15:0] dep;
    logic [15:0] w0;
    logic [15:0] w1;
    logic [15:0] w2;
  } row_t;

  logic [2:0]   state_q, state_d;
  sprite_oam_pkg::req_t req_q, req_d;
  logic [P-1:0] active_q, active_d, visible_q, visible_d;
  logic [P-1:0] rvalid_q, rvalid_d, hid_q, hid_d;
  logic [W-1:0] ra_q, ra_d;
  logic [W:0]   cnt_q, cnt_d;
  logic [W:0]   k_q, k_d;
  logic         pv_q, pv_d;
  logic         best_v_q, best_v_d;
  logic [W+15:0] best_q, best_d, lastk_q, lastk_d;
  logic         first_q, first_d;
  logic         res_v_q, res_v_d;
  sprite_oam_pkg::res_t res_q, res_d;

  // slot row memory
  row_t         mem [P];
  row_t         rd_q;
  logic         we;
  logic [W-1:0] wa;
  row_t         wd;

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rd_q <= mem[ra_d];
  end

  // read row with reset value and hide-all override applied
  row_t cur, nrow;
  logic [W+15:0] ckey;
  always_comb begin
    cur = rd_q;
    if (!rvalid_q[ra_q]) begin
      cur = '{y: sprite_oam_pkg::Y_RESET, dep: 16'd0, w0: 16'd0, w1: 16'd0, w2: 16'd0};
    end
    if (hid_q[ra_q]) cur.w0 = sprite_oam_pkg::HIDDEN_WORD;
    ckey = {cur.dep, ra_q};
  end

  always_comb begin
    state_d   = state_q;
    req_d     = req_q;
    active_d  = active_q;
    visible_d = visible_q;
    rvalid_d  = rvalid_q;
    hid_d     = hid_q;
    ra_d      = ra_q;
    cnt_d     = cnt_q;
    k_d       = k_q;
    pv_d      = 1'b0;
    best_v_d  = best_v_q;
    best_d    = best_q;
    lastk_d   = lastk_q;
    first_d   = first_q;
    res_v_d   = 1'b0;
    res_d     = '0;
    res_d.last = 1'b1;
    we        = 1'b0;
    wa        = req_q.slot[W-1:0];
    wd        = cur;
    nrow      = cur;

    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          req_d = req_i;
          if (req_i.mode == sprite_oam_pkg::MODE_CREATE) begin
            cnt_d   = '0;
            state_d = S_CRE;
          end else if (req_i.mode == sprite_oam_pkg::MODE_RENDER) begin
            k_d      = '0;
            first_d  = 1'b1;
            cnt_d    = '0;
            best_v_d = 1'b0;
            state_d  = S_SCAN;
          end else if (req_i.mode == sprite_oam_pkg::MODE_HIDE_ALL) begin
            visible_d = '0;
            hid_d     = '1;
            res_v_d   = 1'b1;
          end else if (req_i.mode > sprite_oam_pkg::MODE_HIDE_ALL) begin
            res_v_d = 1'b1;
          end else if (req_i.slot >= 7'(P)) begin
            res_v_d        = 1'b1;
            res_d.status   = sprite_oam_pkg::ST_BAD;
            res_d.slot_id  = req_i.slot[5:0];
          end else begin
            ra_d    = req_i.slot[W-1:0];
            state_d = S_UPD;
          end
        end
      end

      // read-modify-write of the addressed slot
      S_UPD: begin
        case (req_q.mode)
          sprite_oam_pkg::MODE_DESTROY: begin
            active_d[wa]  = 1'b0;
            visible_d[wa] = 1'b0;
            nrow.w0       = sprite_oam_pkg::HIDDEN_WORD;
          end
          sprite_oam_pkg::MODE_POSITION: begin
            nrow.y  = req_q.y_pos;
            nrow.w0 = {cur.w0[15:8], req_q.y_pos[7:0]};
            nrow.w1 = {cur.w1[15:9], req_q.x_pos[8:0]};
          end
          sprite_oam_pkg::MODE_TILE: nrow.w2 = {cur.w2[15:10], 2'b00, req_q.tile};
          sprite_oam_pkg::MODE_VISIBLE: begin
            visible_d[wa] = req_q.show;
            nrow.w0 = req_q.show ? {cur.w0[15:8], cur.y[7:0]} : sprite_oam_pkg::HIDDEN_WORD;
          end
          sprite_oam_pkg::MODE_PRIORITY:
            nrow.w2 = {cur.w2[15:12], req_q.priority_req, cur.w2[9:0]};
          default: nrow.dep = req_q.depth;
        endcase
        we            = 1'b1;
        wd            = nrow;
        rvalid_d[wa]  = 1'b1;
        hid_d[wa]     = 1'b0;
        res_v_d       = 1'b1;
        res_d.slot_id = 6'(wa);
        state_d       = S_IDLE;
      end

      // free-slot search, one slot per cycle
      S_CRE: begin
        if (!active_q[cnt_q[W-1:0]]) begin
          wa = cnt_q[W-1:0];
          wd = '{y:   req_q.y_pos,
                 dep: req_q.y_pos,
                 w0:  {req_q.shape, 6'd0, req_q.y_pos[7:0]},
                 w1:  {2'b00, req_q.size_code, 3'd0, req_q.x_pos[8:0]},
                 w2:  {req_q.palette, req_q.priority_req, 2'b00, req_q.tile}};
          we            = 1'b1;
          active_d[wa]  = 1'b1;
          visible_d[wa] = 1'b1;
          rvalid_d[wa]  = 1'b1;
          hid_d[wa]     = 1'b0;
          res_v_d       = 1'b1;
          res_d.slot_id = 6'(wa);
          state_d       = S_IDLE;
        end else if (cnt_q == (W+1)'(P - 1)) begin
          res_v_d      = 1'b1;
          res_d.status = sprite_oam_pkg::ST_NO_FREE;
          state_d      = S_IDLE;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end

      // pool scan: smallest (depth, slot) key above the last one emitted
      S_SCAN: begin
        if (pv_q && active_q[ra_q] && visible_q[ra_q] && (first_q || ckey > lastk_q)
            && (!best_v_q || ckey < best_q)) begin
          best_v_d = 1'b1;
          best_d   = ckey;
        end
        if (cnt_q != (W+1)'(P)) begin
          ra_d  = cnt_q[W-1:0];
          pv_d  = 1'b1;
          cnt_d = cnt_q + 1'b1;
        end else begin
          state_d = S_FETCH;
        end
      end

      S_FETCH: begin
        ra_d    = best_q[W-1:0];
        state_d = S_EMIT;
      end

      // one OAM entry out
      S_EMIT: begin
        res_v_d         = 1'b1;
        res_d.oam_index = 6'(k_q);
        res_d.last      = (k_q == (W+1)'(N - 1));
        if (best_v_q) begin
          res_d.slot_id   = 6'(ra_q);
          res_d.attr_zero = cur.w0;
          res_d.attr_one  = cur.w1;
          res_d.attr_two  = cur.w2;
          lastk_d         = best_q;
          first_d         = 1'b0;
        end else begin
          res_d.attr_zero = sprite_oam_pkg::HIDDEN_WORD;
        end
        if (k_q == (W+1)'(N - 1)) begin
          state_d = S_IDLE;
        end else begin
          k_d = k_q + 1'b1;
          if (best_v_q) begin
            cnt_d    = '0;
            best_v_d = 1'b0;
            state_d  = S_SCAN;
          end
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      active_q  <= '0;
      visible_q <= '0;
      rvalid_q  <= '0;
      hid_q     <= '0;
      pv_q      <= 1'b0;
      best_v_q  <= 1'b0;
      first_q   <= 1'b1;
      cnt_q     <= '0;
      k_q       <= '0;
      res_v_q   <= 1'b0;
    end else begin
      state_q   <= state_d;
      active_q  <= active_d;
      visible_q <= visible_d;
      rvalid_q  <= rvalid_d;
      hid_q     <= hid_d;
      pv_q      <= pv_d;
      best_v_q  <= best_v_d;
      first_q   <= first_d;
      cnt_q     <= cnt_d;
      k_q       <= k_d;
      res_v_q   <= res_v_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    req_q   <= req_d;
    ra_q    <= ra_d;
    best_q  <= best_d;
    lastk_q <= lastk_d;
    res_q   <= res_d;
  end

  assign busy_o      = (state_q != S_IDLE);
  assign res_valid_o = res_v_q;
  assign res_o       = res_q;

endmodule
